FILE: hw/rtl/nnsa_pkg.sv
// Shared types, widths, register indexes and helpers for the scale addresser.
// No dependencies; compiled first.
package nnsa_pkg;

   localparam int DIM_W         = 13;
   localparam int PITCH_W       = 14;
   localparam int COORD_W       = 12;
   localparam int IDX_W         = 25;
   localparam int CSR_IDX_W     = 3;
   localparam int CSR_DATA_W    = 14;
   localparam int MAX_DIM_DEF   = 4096;
   localparam int FRAC_BITS_DEF = 16;

   typedef logic [CSR_IDX_W-1:0] csr_idx_type;

   localparam csr_idx_type CSR_SRC_WIDTH  = 3'd0;
   localparam csr_idx_type CSR_SRC_HEIGHT = 3'd1;
   localparam csr_idx_type CSR_DST_WIDTH  = 3'd2;
   localparam csr_idx_type CSR_DST_HEIGHT = 3'd3;
   localparam csr_idx_type CSR_SRC_PITCH  = 3'd4;
   localparam csr_idx_type CSR_DST_PITCH  = 3'd5;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

   // zero reads as one, anything above max_dim as max_dim
   function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                  input int max_dim);
      logic [DIM_W-1:0] r;
      if (v == '0) begin
         r = DIM_W'(1);
      end else if (int'(v) > max_dim) begin
         r = DIM_W'(max_dim);
      end else begin
         r = v;
      end
      return r;
   endfunction

endpackage

FILE: hw/rtl/nnsa_if.sv
// Request and response channel interfaces of the scale addresser.
// Depends on nnsa_pkg.
interface nnsa_req_if import nnsa_pkg::*; ();
   logic valid;
   logic ready;
   logic restart;

   modport source (output valid, output restart, input ready);
   modport sink (input valid, input restart, output ready);
endinterface

interface nnsa_rsp_if import nnsa_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [COORD_W-1:0] out_dest_x;
   logic [COORD_W-1:0] out_dest_y;
   logic [COORD_W-1:0] out_source_x;
   logic [COORD_W-1:0] out_source_y;
   logic [IDX_W-1:0]   dest_index;
   logic [IDX_W-1:0]   source_index;
   logic               frame_last;

   modport source (output valid, output out_dest_x, output out_dest_y,
                   output out_source_x, output out_source_y, output dest_index,
                   output source_index, output frame_last, input ready);
   modport sink (input valid, input out_dest_x, input out_dest_y,
                 input out_source_x, input out_source_y, input dest_index,
                 input source_index, input frame_last, output ready);
endinterface

FILE: hw/rtl/nnsa_div.sv
// Shared restoring divider, one quotient bit per cycle.
// Depends on nnsa_pkg for the status struct.
module nnsa_div import nnsa_pkg::*; #(
   parameter int DVD_W = DIM_W + FRAC_BITS_DEF,
   parameter int DVS_W = DIM_W
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DVD_W-1:0] dividend,
   input  logic [DVS_W-1:0] divisor,
   output logic [DVD_W-1:0] quotient,
   output div_stat_type     stat
);

   localparam int CNT_W = $clog2(DVD_W + 1);

   logic [DVD_W-1:0] quo_ff, quo_in;
   logic [DVS_W-1:0] rem_ff, rem_in;
   logic [DVS_W-1:0] dvs_ff, dvs_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [DVS_W:0]   rem_sh;
   logic [DVS_W+1:0] diff;

   always_comb begin
      rem_sh  = {rem_ff, quo_ff[DVD_W-1]};
      diff    = {1'b0, rem_sh} - {2'b00, dvs_ff};
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
         cnt_in  = CNT_W'(DVD_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!diff[DVS_W+1]) begin
            rem_in = diff[DVS_W-1:0];
            quo_in = {quo_ff[DVD_W-2:0], 1'b1};
         end else begin
            rem_in = rem_sh[DVS_W-1:0];
            quo_in = {quo_ff[DVD_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign quotient  = quo_ff;
   assign stat.busy = busy_ff;
   assign stat.done = done_ff;

endmodule

FILE: hw/rtl/nearest_neighbor_scale_addresser.sv
// Nearest-neighbor scale address generator: one pixel address pair per request.
// Within a frame an accepted request goes straight to emit, where its response is
// registered; a frame-start request first runs two serial divisions (x, then y step).
// Requests are taken only in idle, one in flight; the shared divider sets frame-start cost.
// Reset (synchronous): registers to 1, counters and steps cleared, no channel busy.
// Depends on nnsa_pkg, nnsa_if, nnsa_div.
module nearest_neighbor_scale_addresser import nnsa_pkg::*; #(
   parameter int MAX_DIM   = MAX_DIM_DEF,
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   nnsa_req_if.sink              req_if,
   nnsa_rsp_if.source            rsp_if,
   input  logic                  csr_we,
   input  csr_idx_type           csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   localparam int CNT_W = $clog2(MAX_DIM);
   localparam int INC_W = DIM_W + FRAC_BITS;
   localparam int ACC_W = INC_W + CNT_W;
   localparam int SY_W  = ACC_W - FRAC_BITS;
   localparam int CMP_W = (CNT_W + 1 > DIM_W) ? CNT_W + 1 : DIM_W;

   typedef enum logic [2:0] {
      ST_IDLE, ST_XSTART, ST_XWAIT, ST_YSTART, ST_YWAIT, ST_EMIT
   } state_type;

   state_type          state_ff, state_in;
   logic [DIM_W-1:0]   src_w_ff, src_w_in, src_h_ff, src_h_in;
   logic [DIM_W-1:0]   dst_w_ff, dst_w_in, dst_h_ff, dst_h_in;
   logic [PITCH_W-1:0] src_p_ff, src_p_in, dst_p_ff, dst_p_in;
   logic [CNT_W-1:0]   col_ff, col_in, row_ff, row_in;
   logic [ACC_W-1:0]   xacc_ff, xacc_in, yacc_ff, yacc_in;
   logic [INC_W-1:0]   xinc_ff, xinc_in, yinc_ff, yinc_in;
   logic               steps_valid_ff, steps_valid_in;
   logic               rsp_valid_ff, rsp_valid_in;

   logic [COORD_W-1:0] dx_ff, dx_in, dy_ff, dy_in, sx_ff, sx_in, sy_ff, sy_in;
   logic [IDX_W-1:0]   didx_ff, didx_in, sidx_ff, sidx_in;
   logic               last_ff, last_in;

   logic                  div_start;
   logic [INC_W-1:0]      div_dividend, div_quotient;
   logic [DIM_W-1:0]      div_divisor;
   div_stat_type          div_stat;

   logic [DIM_W-1:0]      dw, dh;
   logic                  row_end, col_end, emit_go, accept;
   logic [SY_W-1:0]       sxw, syw;
   logic [CNT_W+PITCH_W-1:0] dprod;
   logic [SY_W+PITCH_W-1:0]  sprod;

   assign div_start = (state_ff == ST_XSTART) || (state_ff == ST_YSTART);
   assign div_dividend = (state_ff == ST_XSTART)
      ? {clamp_dim(src_w_ff, MAX_DIM), FRAC_BITS'(0)}
      : {clamp_dim(src_h_ff, MAX_DIM), FRAC_BITS'(0)};
   assign div_divisor = (state_ff == ST_XSTART) ? clamp_dim(dst_w_ff, MAX_DIM)
                                                : clamp_dim(dst_h_ff, MAX_DIM);

   nnsa_div #(
      .DVD_W (INC_W),
      .DVS_W (DIM_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .quotient (div_quotient),
      .stat     (div_stat)
   );

   assign accept       = req_if.valid && req_if.ready;
   assign req_if.ready = (state_ff == ST_IDLE);
   assign emit_go      = (state_ff == ST_EMIT) && (!rsp_valid_ff || rsp_if.ready);

   always_comb begin
      dw      = clamp_dim(dst_w_ff, MAX_DIM);
      dh      = clamp_dim(dst_h_ff, MAX_DIM);
      row_end = (CMP_W'(row_ff) + CMP_W'(1)) >= CMP_W'(dh);
      col_end = (CMP_W'(col_ff) + CMP_W'(1)) >= CMP_W'(dw);
      sxw     = xacc_ff[ACC_W-1:FRAC_BITS];
      syw     = yacc_ff[ACC_W-1:FRAC_BITS];
      dprod   = row_ff * dst_p_ff;
      sprod   = syw * src_p_ff;
      dx_in   = COORD_W'(col_ff);
      dy_in   = COORD_W'(row_ff);
      sx_in   = COORD_W'(sxw);
      sy_in   = COORD_W'(syw);
      didx_in = IDX_W'(dprod) + IDX_W'(col_ff);
      sidx_in = IDX_W'(sprod) + IDX_W'(sxw);
      last_in = row_end && col_end;
   end

   always_comb begin
      state_in       = state_ff;
      src_w_in       = src_w_ff;
      src_h_in       = src_h_ff;
      dst_w_in       = dst_w_ff;
      dst_h_in       = dst_h_ff;
      src_p_in       = src_p_ff;
      dst_p_in       = dst_p_ff;
      col_in         = col_ff;
      row_in         = row_ff;
      xacc_in        = xacc_ff;
      yacc_in        = yacc_ff;
      xinc_in        = xinc_ff;
      yinc_in        = yinc_ff;
      steps_valid_in = steps_valid_ff;
      rsp_valid_in   = rsp_if.ready ? 1'b0 : rsp_valid_ff;

      if (csr_we) begin
         unique case (csr_index)
            CSR_SRC_WIDTH:  src_w_in = csr_data[DIM_W-1:0];
            CSR_SRC_HEIGHT: src_h_in = csr_data[DIM_W-1:0];
            CSR_DST_WIDTH:  dst_w_in = csr_data[DIM_W-1:0];
            CSR_DST_HEIGHT: dst_h_in = csr_data[DIM_W-1:0];
            CSR_SRC_PITCH:  src_p_in = csr_data[PITCH_W-1:0];
            CSR_DST_PITCH:  dst_p_in = csr_data[PITCH_W-1:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_if.restart || !steps_valid_ff) begin
                  col_in         = '0;
                  row_in         = '0;
                  xacc_in        = '0;
                  yacc_in        = '0;
                  steps_valid_in = 1'b1;
                  state_in       = ST_XSTART;
               end else begin
                  state_in = ST_EMIT;
               end
            end
         end
         ST_XSTART: state_in = ST_XWAIT;
         ST_XWAIT: begin
            if (div_stat.done) begin
               xinc_in  = div_quotient;
               state_in = ST_YSTART;
            end
         end
         ST_YSTART: state_in = ST_YWAIT;
         ST_YWAIT: begin
            if (div_stat.done) begin
               yinc_in  = div_quotient;
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (emit_go) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
               if (!row_end) begin
                  row_in  = row_ff + CNT_W'(1);
                  yacc_in = yacc_ff + ACC_W'(yinc_ff);
               end else begin
                  row_in  = '0;
                  yacc_in = '0;
                  if (!col_end) begin
                     col_in  = col_ff + CNT_W'(1);
                     xacc_in = xacc_ff + ACC_W'(xinc_ff);
                  end else begin
                     col_in         = '0;
                     xacc_in        = '0;
                     steps_valid_in = 1'b0;
                  end
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         src_w_ff       <= DIM_W'(1);
         src_h_ff       <= DIM_W'(1);
         dst_w_ff       <= DIM_W'(1);
         dst_h_ff       <= DIM_W'(1);
         src_p_ff       <= PITCH_W'(1);
         dst_p_ff       <= PITCH_W'(1);
         col_ff         <= '0;
         row_ff         <= '0;
         xacc_ff        <= '0;
         yacc_ff        <= '0;
         xinc_ff        <= '0;
         yinc_ff        <= '0;
         steps_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         dx_ff          <= '0;
         dy_ff          <= '0;
         sx_ff          <= '0;
         sy_ff          <= '0;
         didx_ff        <= '0;
         sidx_ff        <= '0;
         last_ff        <= 1'b0;
      end else begin
         state_ff       <= state_in;
         src_w_ff       <= src_w_in;
         src_h_ff       <= src_h_in;
         dst_w_ff       <= dst_w_in;
         dst_h_ff       <= dst_h_in;
         src_p_ff       <= src_p_in;
         dst_p_ff       <= dst_p_in;
         col_ff         <= col_in;
         row_ff         <= row_in;
         xacc_ff        <= xacc_in;
         yacc_ff        <= yacc_in;
         xinc_ff        <= xinc_in;
         yinc_ff        <= yinc_in;
         steps_valid_ff <= steps_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
         if (emit_go) begin
            dx_ff   <= dx_in;
            dy_ff   <= dy_in;
            sx_ff   <= sx_in;
            sy_ff   <= sy_in;
            didx_ff <= didx_in;
            sidx_ff <= sidx_in;
            last_ff <= last_in;
         end
      end
   end

   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.out_dest_x   = dx_ff;
   assign rsp_if.out_dest_y   = dy_ff;
   assign rsp_if.out_source_x = sx_ff;
   assign rsp_if.out_source_y = sy_ff;
   assign rsp_if.dest_index   = didx_ff;
   assign rsp_if.source_index = sidx_ff;
   assign rsp_if.frame_last   = last_ff;

`ifndef SYNTHESIS
   a_rsp_from_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_EMIT))
      else $error("response raised outside emit");

   a_ready_div_idle: assert property (@(posedge clock) disable iff (reset)
      req_if.ready |-> !div_stat.busy)
      else $error("request taken while divider busy");

   a_last_wraps: assert property (@(posedge clock) disable iff (reset)
      (emit_go && last_in) |=> (!steps_valid_ff && col_ff == '0 && row_ff == '0))
      else $error("frame did not wrap after last pixel");

   a_div_to_emit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_YWAIT && div_stat.done) |=> (state_ff == ST_EMIT))
      else $error("step division did not hand off to emit");
`endif

endmodule

FILE: test/tb_top.sv
`timescale 1ns / 1ps
// Testbench for nearest_neighbor_scale_addresser: a directed request table, then random
// frames under bursty requests and response back-pressure, scored against a predictor.
// Depends on nnsa_pkg, nnsa_if and the scale addresser RTL.
module tb_top;
   import nnsa_pkg::*;

   typedef struct packed {
      logic [COORD_W-1:0] dest_x;
      logic [COORD_W-1:0] dest_y;
      logic [COORD_W-1:0] source_x;
      logic [COORD_W-1:0] source_y;
      logic [IDX_W-1:0]   dest_index;
      logic [IDX_W-1:0]   source_index;
      logic               frame_last;
   } pixel_addr_type;

   typedef enum logic {ROW_CSR, ROW_REQ} row_kind_type;
   typedef enum logic [1:0] {PACE_OPEN, PACE_COIN, PACE_THIRD, PACE_MOSTLY} pace_type;

   typedef struct {
      row_kind_type          kind;
      csr_idx_type           index;
      logic [CSR_DATA_W-1:0] data;
      logic                  restart;
      bit                    fixed;
      pixel_addr_type        result;
   } script_row_type;

   localparam int SCRIPT_LEN   = 32;
   localparam int RANDOM_ITEMS = 1500;
   localparam pixel_addr_type ORIGIN      = '{'0, '0, '0, '0, '0, '0, 1'b0};
   localparam pixel_addr_type ORIGIN_LAST = '{'0, '0, '0, '0, '0, '0, 1'b1};

   logic                  clock;
   logic                  reset;
   logic                  csr_we;
   csr_idx_type           csr_index;
   logic [CSR_DATA_W-1:0] csr_data;

   nnsa_req_if req_ch ();
   nnsa_rsp_if rsp_ch ();

   nearest_neighbor_scale_addresser u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_ch),
      .rsp_if    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   // predictor state
   logic [DIM_W-1:0]   cfg_src_w, cfg_src_h, cfg_dst_w, cfg_dst_h;
   logic [PITCH_W-1:0] cfg_src_pitch, cfg_dst_pitch;
   logic [63:0]        col_cnt, row_cnt, x_acc, y_acc, x_step, y_step;
   bit                 steps_ready;

   pixel_addr_type expected_pixels [$];
   int             mismatch_count = 0;
   int             burst_left = 0;
   bit             gapless = 1'b0;
   bit             hold_request = 1'b0;
   script_row_type script [SCRIPT_LEN];
   csr_idx_type    reg_list [6] = '{CSR_SRC_WIDTH, CSR_SRC_HEIGHT, CSR_DST_WIDTH,
                                    CSR_DST_HEIGHT, CSR_SRC_PITCH, CSR_DST_PITCH};

   function automatic logic [63:0] bound_dim(input logic [DIM_W-1:0] v);
      logic [63:0] r;
      r = 64'(v);
      if (r == 0) begin
         r = 1;
      end else if (r > MAX_DIM_DEF) begin
         r = MAX_DIM_DEF;
      end
      return r;
   endfunction

   function automatic pixel_addr_type predict_pixel(input logic restart);
      pixel_addr_type r;
      logic [63:0] dw, dh, sx, sy;
      if (restart || !steps_ready) begin
         x_step = (bound_dim(cfg_src_w) << FRAC_BITS_DEF) / bound_dim(cfg_dst_w);
         y_step = (bound_dim(cfg_src_h) << FRAC_BITS_DEF) / bound_dim(cfg_dst_h);
         col_cnt = 0;
         row_cnt = 0;
         x_acc = 0;
         y_acc = 0;
         steps_ready = 1'b1;
      end
      dw = bound_dim(cfg_dst_w);
      dh = bound_dim(cfg_dst_h);
      sx = x_acc >> FRAC_BITS_DEF;
      sy = y_acc >> FRAC_BITS_DEF;
      r.dest_x       = col_cnt[COORD_W-1:0];
      r.dest_y       = row_cnt[COORD_W-1:0];
      r.source_x     = sx[COORD_W-1:0];
      r.source_y     = sy[COORD_W-1:0];
      r.dest_index   = IDX_W'(row_cnt * cfg_dst_pitch + col_cnt);
      r.source_index = IDX_W'(sy * cfg_src_pitch + sx);
      r.frame_last   = (row_cnt + 1 >= dh) && (col_cnt + 1 >= dw);
      if (row_cnt + 1 < dh) begin
         row_cnt = row_cnt + 1;
         y_acc = y_acc + y_step;
      end else begin
         row_cnt = 0;
         y_acc = 0;
         if (col_cnt + 1 < dw) begin
            col_cnt = col_cnt + 1;
            x_acc = x_acc + x_step;
         end else begin
            col_cnt = 0;
            x_acc = 0;
            steps_ready = 1'b0;
         end
      end
      return r;
   endfunction

   function automatic script_row_type csr_row(input csr_idx_type idx,
                                              input logic [CSR_DATA_W-1:0] data);
      script_row_type r;
      r = '{ROW_CSR, idx, data, 1'b0, 1'b0, ORIGIN};
      return r;
   endfunction

   function automatic script_row_type req_row(input logic restart, input bit fixed,
                                              input pixel_addr_type result);
      script_row_type r;
      r = '{ROW_REQ, CSR_SRC_WIDTH, '0, restart, fixed, result};
      return r;
   endfunction

   function automatic logic [CSR_DATA_W-1:0] rand_dim();
      int unsigned pick;
      logic [CSR_DATA_W-1:0] v;
      pick = $urandom_range(0, 9);
      if (pick < 7) begin
         v = CSR_DATA_W'($urandom_range(1, 8));
      end else if (pick == 7) begin
         v = CSR_DATA_W'($urandom_range(1, 64));
      end else if (pick == 8) begin
         case ($urandom_range(0, 4))
            0: v = '0;
            1: v = CSR_DATA_W'(1);
            2: v = CSR_DATA_W'(4096);
            3: v = CSR_DATA_W'(4097);
            default: v = CSR_DATA_W'(8191);
         endcase
      end else begin
         v = CSR_DATA_W'($urandom_range(0, 16383));
      end
      return v;
   endfunction

   function automatic logic [CSR_DATA_W-1:0] rand_pitch();
      int unsigned pick;
      logic [CSR_DATA_W-1:0] v;
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
         v = '0;
      end else if (pick == 1) begin
         v = CSR_DATA_W'(16383);
      end else begin
         v = CSR_DATA_W'($urandom_range(0, 16383));
      end
      return v;
   endfunction

   task automatic write_csr(input csr_idx_type idx, input logic [CSR_DATA_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      case (idx)
         CSR_SRC_WIDTH:  cfg_src_w = data[DIM_W-1:0];
         CSR_SRC_HEIGHT: cfg_src_h = data[DIM_W-1:0];
         CSR_DST_WIDTH:  cfg_dst_w = data[DIM_W-1:0];
         CSR_DST_HEIGHT: cfg_dst_h = data[DIM_W-1:0];
         CSR_SRC_PITCH:  cfg_src_pitch = data[PITCH_W-1:0];
         CSR_DST_PITCH:  cfg_dst_pitch = data[PITCH_W-1:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic drain();
      do @(posedge clock); while (expected_pixels.size() != 0);
   endtask

   task automatic offer(input logic restart, input bit fixed,
                        input pixel_addr_type result);
      pixel_addr_type calc;
      int unsigned gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = gapless ? 0 : $urandom_range(0, 7);
         if (gap != 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_ch.valid   <= 1'b1;
      req_ch.restart <= restart;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      calc = predict_pixel(restart);
      expected_pixels.push_back(fixed ? result : calc);
   endtask

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #8_000_000;
      $display("** nearest_neighbor_scale_addresser: FAILED **");
      $finish;
   end

   // response side: changing pace, plus one long hold-off on request
   initial begin : rsp_pace
      pace_type    mode;
      int unsigned left, hold_left, tick;
      mode = PACE_OPEN;
      left = 0;
      hold_left = 0;
      tick = 0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         tick++;
         if (left == 0) begin
            mode = pace_type'($urandom_range(0, 3));
            left = $urandom_range(16, 200);
         end
         left--;
         if (hold_request && hold_left == 0) begin
            hold_left = 300;
         end
         if (hold_left != 0) begin
            hold_left--;
            if (hold_left == 0) begin
               hold_request = 1'b0;
            end
            rsp_ch.ready <= 1'b0;
         end else begin
            case (mode)
               PACE_OPEN:   rsp_ch.ready <= 1'b1;
               PACE_COIN:   rsp_ch.ready <= 1'($urandom_range(0, 1));
               PACE_THIRD:  rsp_ch.ready <= (tick % 3 == 0);
               default:     rsp_ch.ready <= ($urandom_range(0, 9) != 0);
            endcase
         end
      end
   end

   always @(posedge clock) begin : check_rsp
      pixel_addr_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_pixels.size() == 0) begin
            $error("response with no request pending");
            mismatch_count++;
         end else begin
            want = expected_pixels.pop_front();
            if (rsp_ch.out_dest_x !== want.dest_x) begin
               $error("out_dest_x expected %0d got %0d", want.dest_x, rsp_ch.out_dest_x);
               mismatch_count++;
            end
            if (rsp_ch.out_dest_y !== want.dest_y) begin
               $error("out_dest_y expected %0d got %0d", want.dest_y, rsp_ch.out_dest_y);
               mismatch_count++;
            end
            if (rsp_ch.out_source_x !== want.source_x) begin
               $error("out_source_x expected %0d got %0d", want.source_x,
                      rsp_ch.out_source_x);
               mismatch_count++;
            end
            if (rsp_ch.out_source_y !== want.source_y) begin
               $error("out_source_y expected %0d got %0d", want.source_y,
                      rsp_ch.out_source_y);
               mismatch_count++;
            end
            if (rsp_ch.dest_index !== want.dest_index) begin
               $error("dest_index expected %0d got %0d", want.dest_index,
                      rsp_ch.dest_index);
               mismatch_count++;
            end
            if (rsp_ch.source_index !== want.source_index) begin
               $error("source_index expected %0d got %0d", want.source_index,
                      rsp_ch.source_index);
               mismatch_count++;
            end
            if (rsp_ch.frame_last !== want.frame_last) begin
               $error("frame_last expected %0d got %0d", want.frame_last,
                      rsp_ch.frame_last);
               mismatch_count++;
            end
         end
      end
   end

   initial begin : stimulus
      int sent, phase, count;
      bit pressure;
      req_ch.valid   <= 1'b0;
      req_ch.restart <= 1'b0;
      csr_we         <= 1'b0;
      csr_index      <= CSR_SRC_WIDTH;
      csr_data       <= '0;
      reset          <= 1'b1;
      cfg_src_w = DIM_W'(1);
      cfg_src_h = DIM_W'(1);
      cfg_dst_w = DIM_W'(1);
      cfg_dst_h = DIM_W'(1);
      cfg_src_pitch = PITCH_W'(1);
      cfg_dst_pitch = PITCH_W'(1);
      col_cnt = 0;
      row_cnt = 0;
      x_acc = 0;
      y_acc = 0;
      x_step = 0;
      y_step = 0;
      steps_ready = 1'b0;

      script = '{
         // reset values: a 1x1 frame, every pixel is the last
         req_row(1'b0, 1'b1, ORIGIN_LAST),
         req_row(1'b1, 1'b1, ORIGIN_LAST),
         req_row(1'b0, 1'b1, ORIGIN_LAST),
         // oversized and zero dimensions, widest pitches
         csr_row(CSR_SRC_WIDTH, 14'd8191),
         csr_row(CSR_SRC_HEIGHT, 14'd0),
         csr_row(CSR_DST_WIDTH, 14'd1),
         csr_row(CSR_DST_HEIGHT, 14'd8191),
         csr_row(CSR_SRC_PITCH, 14'd16383),
         csr_row(CSR_DST_PITCH, 14'd16383),
         req_row(1'b1, 1'b1, ORIGIN),
         req_row(1'b0, 1'b0, ORIGIN),
         req_row(1'b0, 1'b0, ORIGIN),
         // height shrinks below the row counter mid-frame
         csr_row(CSR_DST_HEIGHT, 14'd2),
         req_row(1'b0, 1'b0, ORIGIN),
         req_row(1'b0, 1'b0, ORIGIN),
         // zero pitches
         csr_row(CSR_SRC_HEIGHT, 14'd4096),
         csr_row(CSR_DST_WIDTH, 14'd3),
         csr_row(CSR_SRC_PITCH, 14'd0),
         csr_row(CSR_DST_PITCH, 14'd0),
         req_row(1'b1, 1'b0, ORIGIN),
         req_row(1'b0, 1'b0, ORIGIN),
         req_row(1'b0, 1'b0, ORIGIN),
         // width grows mid-frame, steps kept
         csr_row(CSR_DST_WIDTH, 14'd4097),
         req_row(1'b0, 1'b0, ORIGIN),
         req_row(1'b0, 1'b0, ORIGIN),
         req_row(1'b0, 1'b0, ORIGIN),
         csr_row(CSR_SRC_PITCH, 14'd8192),
         csr_row(CSR_DST_PITCH, 14'd8192),
         csr_row(CSR_DST_HEIGHT, 14'd4096),
         req_row(1'b1, 1'b0, ORIGIN),
         req_row(1'b0, 1'b0, ORIGIN),
         req_row(1'b0, 1'b0, ORIGIN)
      };

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (script[i]) begin
         if (script[i].kind == ROW_CSR) begin
            req_ch.valid <= 1'b0;
            drain();
            write_csr(script[i].index, script[i].data);
         end else begin
            csr_we <= 1'b0;
            offer(script[i].restart, script[i].fixed, script[i].result);
         end
      end

      sent = 0;
      phase = 0;
      while (sent < RANDOM_ITEMS) begin
         req_ch.valid <= 1'b0;
         drain();
         foreach (reg_list[r]) begin
            if (phase == 0 || $urandom_range(0, 1) == 1) begin
               if (reg_list[r] == CSR_SRC_PITCH || reg_list[r] == CSR_DST_PITCH) begin
                  write_csr(reg_list[r], rand_pitch());
               end else begin
                  write_csr(reg_list[r], rand_dim());
               end
            end
         end
         csr_we <= 1'b0;
         pressure = (phase == 4);
         gapless = pressure;
         if (pressure) begin
            hold_request = 1'b1;
         end
         count = pressure ? 60 : $urandom_range(8, 60);
         for (int k = 0; k < count; k++) begin
            if (k == 0) begin
               offer($urandom_range(0, 3) != 0, 1'b0, ORIGIN);
            end else begin
               offer($urandom_range(0, 15) == 0, 1'b0, ORIGIN);
            end
            sent++;
         end
         gapless = 1'b0;
         phase++;
      end

      req_ch.valid <= 1'b0;
      drain();
      repeat (80) @(posedge clock);
      if (mismatch_count == 0 && expected_pixels.size() == 0) begin
         $display("** nearest_neighbor_scale_addresser: PASSED **");
      end else begin
         $display("** nearest_neighbor_scale_addresser: FAILED **");
      end
      $finish;
   end

endmodule

FILE: nearest_neighbor_scale_addresser.f
hw/rtl/nnsa_pkg.sv
hw/rtl/nnsa_if.sv
hw/rtl/nnsa_div.sv
hw/rtl/nearest_neighbor_scale_addresser.sv
test/tb_top.sv
